### sv/etsc_pkg.sv
`default_nettype none

package etsc_pkg;

   // Scanner states
   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [2:0] ST_VAR   = 3'd1;
   localparam logic [2:0] ST_INT   = 3'd2;
   localparam logic [2:0] ST_POINT = 3'd3;
   localparam logic [2:0] ST_FLOAT = 3'd4;
   localparam logic [2:0] ST_ERROR = 3'd5;

   // Character classes
   localparam logic [2:0] CL_LETTER = 3'd0;
   localparam logic [2:0] CL_DIGIT  = 3'd1;
   localparam logic [2:0] CL_DOT    = 3'd2;
   localparam logic [2:0] CL_OP     = 3'd3;
   localparam logic [2:0] CL_SPACE  = 3'd4;
   localparam logic [2:0] CL_OTHER  = 3'd5;

   // Input transaction kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Result kinds
   localparam logic [1:0] RK_TOKEN      = 2'd0;
   localparam logic [1:0] RK_BAD_CHAR   = 2'd1;
   localparam logic [1:0] RK_INCOMPLETE = 2'd2;

   // Token types
   localparam logic [3:0] TT_VAR    = 4'd0;
   localparam logic [3:0] TT_INT    = 4'd1;
   localparam logic [3:0] TT_FLOAT  = 4'd2;
   localparam logic [3:0] TT_ASSIGN = 4'd3;
   localparam logic [3:0] TT_PLUS   = 4'd4;
   localparam logic [3:0] TT_MINUS  = 4'd5;
   localparam logic [3:0] TT_TIMES  = 4'd6;
   localparam logic [3:0] TT_DIVIDE = 4'd7;
   localparam logic [3:0] TT_LPAREN = 4'd8;
   localparam logic [3:0] TT_RPAREN = 4'd9;

   // Characters
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // Result queue
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;

   typedef struct packed {
      logic [2:0] char_class;
      logic [3:0] op_type;
   } class_info_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  token_type;
      logic [31:0] start_position;
      logic [15:0] token_length;
      logic [7:0]  bad_character;
      logic        last_of_run;
   } rsp_item_type;

   // Up to two results produced by one step of the scanner
   typedef struct packed {
      logic [1:0]   n_items;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

### sv/etsc_req_if.sv
`default_nettype none

interface etsc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] character;

   modport source (output valid, output kind, output character, input ready);
   modport sink   (input valid, input kind, input character, output ready);
endinterface

`default_nettype wire

### sv/etsc_rsp_if.sv
`default_nettype none

interface etsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  token_type;
   logic [31:0] start_position;
   logic [15:0] token_length;
   logic [7:0]  bad_character;
   logic        last_of_run;

   modport source (output valid, output result_kind, output token_type,
                   output start_position, output token_length,
                   output bad_character, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input token_type,
                   input start_position, input token_length,
                   input bad_character, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/etsc_classify.sv
`default_nettype none

module etsc_classify (
   input  logic [7:0]                character,
   output etsc_pkg::class_info_type  cinfo
);

   always_comb begin
      cinfo.op_type = etsc_pkg::TT_VAR;
      if (character >= etsc_pkg::CH_LOWER_A && character <= etsc_pkg::CH_LOWER_Z) begin
         cinfo.char_class = etsc_pkg::CL_LETTER;
      end else if (character >= etsc_pkg::CH_ZERO && character <= etsc_pkg::CH_NINE) begin
         cinfo.char_class = etsc_pkg::CL_DIGIT;
      end else begin
         case (character)
            etsc_pkg::CH_DOT: begin
               cinfo.char_class = etsc_pkg::CL_DOT;
            end
            etsc_pkg::CH_EQUAL: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_ASSIGN;
            end
            etsc_pkg::CH_PLUS: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_PLUS;
            end
            etsc_pkg::CH_MINUS: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_MINUS;
            end
            etsc_pkg::CH_STAR: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_TIMES;
            end
            etsc_pkg::CH_SLASH: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_DIVIDE;
            end
            etsc_pkg::CH_LPAREN: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_LPAREN;
            end
            etsc_pkg::CH_RPAREN: begin
               cinfo.char_class = etsc_pkg::CL_OP;
               cinfo.op_type    = etsc_pkg::TT_RPAREN;
            end
            etsc_pkg::CH_SPACE, etsc_pkg::CH_TAB, etsc_pkg::CH_LF, etsc_pkg::CH_CR: begin
               cinfo.char_class = etsc_pkg::CL_SPACE;
            end
            default: begin
               cinfo.char_class = etsc_pkg::CL_OTHER;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/etsc_scan_core.sv
`default_nettype none

module etsc_scan_core #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic                      kind,
   input  logic [7:0]                character,
   input  etsc_pkg::class_info_type  cinfo,
   output etsc_pkg::push_type        push
);

   logic [2:0]               state_ff, state_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [LENGTH_BITS-1:0]   plen_ff, plen_in;

   logic [POSITION_BITS-1:0] pos_inc;
   logic [LENGTH_BITS-1:0]   len_inc;
   logic                     active;
   logic                     err;
   logic [1:0]               n_items;
   etsc_pkg::rsp_item_type   pend_item, op_item, bad_item, inc_item;
   etsc_pkg::rsp_item_type   res_a, res_b;

   // saturating counters
   assign pos_inc = (pos_ff == '1) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign len_inc = (plen_ff == '1) ? plen_ff : plen_ff + LENGTH_BITS'(1);

   assign active = (state_ff == etsc_pkg::ST_START) || (state_ff == etsc_pkg::ST_VAR) ||
                   (state_ff == etsc_pkg::ST_INT)   || (state_ff == etsc_pkg::ST_POINT) ||
                   (state_ff == etsc_pkg::ST_FLOAT);

   always_comb begin
      pend_item.result_kind    = etsc_pkg::RK_TOKEN;
      pend_item.token_type     = (state_ff == etsc_pkg::ST_VAR) ? etsc_pkg::TT_VAR :
                                 (state_ff == etsc_pkg::ST_INT) ? etsc_pkg::TT_INT :
                                                                  etsc_pkg::TT_FLOAT;
      pend_item.start_position = 32'(pstart_ff);
      pend_item.token_length   = 16'(plen_ff);
      pend_item.bad_character  = 8'd0;
      pend_item.last_of_run    = 1'b0;

      op_item.result_kind    = etsc_pkg::RK_TOKEN;
      op_item.token_type     = cinfo.op_type;
      op_item.start_position = 32'(pos_ff);
      op_item.token_length   = 16'd1;
      op_item.bad_character  = 8'd0;
      op_item.last_of_run    = 1'b0;

      bad_item.result_kind    = etsc_pkg::RK_BAD_CHAR;
      bad_item.token_type     = etsc_pkg::TT_VAR;
      bad_item.start_position = 32'(pos_ff);
      bad_item.token_length   = 16'd0;
      bad_item.bad_character  = character;
      bad_item.last_of_run    = 1'b0;

      inc_item.result_kind    = etsc_pkg::RK_INCOMPLETE;
      inc_item.token_type     = etsc_pkg::TT_VAR;
      inc_item.start_position = 32'(pstart_ff);
      inc_item.token_length   = 16'd0;
      inc_item.bad_character  = 8'd0;
      inc_item.last_of_run    = 1'b0;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      n_items   = 2'd0;
      res_a     = pend_item;
      res_b     = op_item;
      err       = 1'b0;

      if (kind == etsc_pkg::KIND_END) begin
         if (state_ff == etsc_pkg::ST_VAR || state_ff == etsc_pkg::ST_INT ||
             state_ff == etsc_pkg::ST_FLOAT) begin
            n_items = 2'd1;
         end else if (state_ff == etsc_pkg::ST_POINT) begin
            n_items = 2'd1;
            res_a   = inc_item;
         end
         state_in  = etsc_pkg::ST_START;
         pos_in    = '0;
         pstart_in = '0;
         plen_in   = '0;
      end else begin
         pos_in = pos_inc;
         if (active) begin
            case (cinfo.char_class)
               etsc_pkg::CL_LETTER: begin
                  if (state_ff == etsc_pkg::ST_START) begin
                     state_in  = etsc_pkg::ST_VAR;
                     pstart_in = pos_ff;
                     plen_in   = LENGTH_BITS'(1);
                  end else if (state_ff == etsc_pkg::ST_VAR) begin
                     plen_in = len_inc;
                  end else if (state_ff == etsc_pkg::ST_INT) begin
                     n_items   = 2'd1;
                     state_in  = etsc_pkg::ST_VAR;
                     pstart_in = pos_ff;
                     plen_in   = LENGTH_BITS'(1);
                  end else begin
                     err = 1'b1;
                  end
               end
               etsc_pkg::CL_DIGIT: begin
                  if (state_ff == etsc_pkg::ST_START) begin
                     state_in  = etsc_pkg::ST_INT;
                     pstart_in = pos_ff;
                     plen_in   = LENGTH_BITS'(1);
                  end else if (state_ff == etsc_pkg::ST_VAR) begin
                     n_items   = 2'd1;
                     state_in  = etsc_pkg::ST_INT;
                     pstart_in = pos_ff;
                     plen_in   = LENGTH_BITS'(1);
                  end else if (state_ff == etsc_pkg::ST_INT) begin
                     plen_in = len_inc;
                  end else begin
                     // digits after the point
                     state_in = etsc_pkg::ST_FLOAT;
                     plen_in  = len_inc;
                  end
               end
               etsc_pkg::CL_DOT: begin
                  if (state_ff == etsc_pkg::ST_INT) begin
                     state_in = etsc_pkg::ST_POINT;
                     plen_in  = len_inc;
                  end else begin
                     err = 1'b1;
                  end
               end
               etsc_pkg::CL_OP: begin
                  if (state_ff == etsc_pkg::ST_POINT) begin
                     err = 1'b1;
                  end else begin
                     if (state_ff != etsc_pkg::ST_START) begin
                        n_items = 2'd2;
                     end else begin
                        n_items = 2'd1;
                        res_a   = op_item;
                     end
                     state_in  = etsc_pkg::ST_START;
                     pstart_in = '0;
                     plen_in   = '0;
                  end
               end
               etsc_pkg::CL_SPACE: begin
                  if (state_ff == etsc_pkg::ST_POINT) begin
                     err = 1'b1;
                  end else begin
                     if (state_ff != etsc_pkg::ST_START) begin
                        n_items = 2'd1;
                     end
                     state_in  = etsc_pkg::ST_START;
                     pstart_in = '0;
                     plen_in   = '0;
                  end
               end
               default: begin
                  err = 1'b1;
               end
            endcase
            if (err) begin
               n_items   = 2'd1;
               res_a     = bad_item;
               state_in  = etsc_pkg::ST_ERROR;
               pstart_in = '0;
               plen_in   = '0;
            end
         end
      end

      if (n_items == 2'd1) begin
         res_a.last_of_run = 1'b1;
      end
      res_b.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= etsc_pkg::ST_START;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else if (fire) begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
      end
   end

   assign push.n_items = fire ? n_items : 2'd0;
   assign push.first   = res_a;
   assign push.second  = res_b;

`ifndef SYNTHESIS
   a_error_has_no_type: assert property (@(posedge clock) disable iff (reset)
      (push.n_items != 2'd0 && push.first.result_kind != etsc_pkg::RK_TOKEN)
         |-> (push.first.token_type == etsc_pkg::TT_VAR &&
              push.first.token_length == 16'd0 && push.n_items == 2'd1))
      else $error("error result carries token data or a second result");
`endif

endmodule

`default_nettype wire

### sv/etsc_rsp_fifo.sv
`default_nettype none

module etsc_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  etsc_pkg::push_type      push,
   input  logic                    pop,
   output logic                    space_ok,
   output logic                    head_valid,
   output etsc_pkg::rsp_item_type  head
);

   localparam int PB = etsc_pkg::RSP_PTR_BITS;
   localparam int CB = etsc_pkg::RSP_CNT_BITS;

   etsc_pkg::rsp_item_type entries_ff [etsc_pkg::RSP_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;
   logic [PB-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + PB'(1);
   assign wr_ptr_in   = wr_ptr_ff + PB'(push.n_items);
   assign rd_ptr_in   = rd_ptr_ff + PB'(pop);
   assign count_in    = count_ff + CB'(push.n_items) - CB'(pop);

   // room for the worst case of one step, no credit for a pop
   assign space_ok   = (count_ff <= CB'(etsc_pkg::RSP_DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.n_items != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.n_items == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(etsc_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.n_items != 2'd0) |-> space_ok)
      else $error("scanner stepped without room for its results");

   a_ptr_count_match: assert property (@(posedge clock) disable iff (reset)
      PB'(wr_ptr_ff - rd_ptr_ff) == count_ff[PB-1:0])
      else $error("queue pointers disagree with count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && wr_ptr_ff == rd_ptr_ff))
      else $error("queue not empty after reset");
`endif

endmodule

`default_nettype wire

### sv/expression_token_scanner.sv
`default_nettype none

// Expression token scanner. Each req_chan transaction carries one byte (kind 0)
// or an end marker (kind 1). Bytes are classed as lowercase letter, digit,
// point, operator (= + - * / ( )), whitespace or other, and a small automaton
// (start, variable, integer, after-point, float, error) builds variable,
// integer and float tokens. Each finished token comes out on rsp_chan as one
// transaction with type, start position and length; operators are reported
// at once, after any token they close. An invalid byte gives an error result
// and every later byte is dropped until the end marker, which flushes a
// pending token (or reports an incomplete float after a bare point) and
// returns the scanner to its reset state. Position and length saturate.
// Rate: one transaction per cycle in, one per cycle out, while rsp_chan is
// ready and the result queue has room. An operator that closes a pending
// token makes two results (the token, then the operator); the 4-entry result
// queue drains one per cycle, so a run of such bytes holds back the input.
// A byte passes the input register, then the scanner step into the queue.
module expression_token_scanner #(
   parameter int POSITION_BITS = 32,
   parameter int LENGTH_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   etsc_req_if.sink    req_chan,
   etsc_rsp_if.source  rsp_chan
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_char_ff;

   logic                      req_take;
   logic                      step;
   logic                      space_ok;
   logic                      head_valid;
   etsc_pkg::class_info_type  cinfo;
   etsc_pkg::push_type        push;
   etsc_pkg::rsp_item_type    head;

   // the held byte steps the scanner once the queue can take two results
   assign step     = in_valid_ff && space_ok;
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_chan.kind;
         in_char_ff <= req_chan.character;
      end
   end

   etsc_classify u_classify (
      .character (in_char_ff),
      .cinfo     (cinfo)
   );

   etsc_scan_core #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_scan_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (step),
      .kind      (in_kind_ff),
      .character (in_char_ff),
      .cinfo     (cinfo),
      .push      (push)
   );

   // result queue; its head drives the response transaction
   etsc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_chan.valid && rsp_chan.ready),
      .space_ok   (space_ok),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_chan.valid          = head_valid;
   assign rsp_chan.result_kind    = head.result_kind;
   assign rsp_chan.token_type     = head.token_type;
   assign rsp_chan.start_position = head.start_position;
   assign rsp_chan.token_length   = head.token_length;
   assign rsp_chan.bad_character  = head.bad_character;
   assign rsp_chan.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire
